// ----- hdl/dfr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delimited frame receiver package
// Shared types and register codes for the delimited frame receiver.
// ----------------------------------------------------------------------------
package dfr_pkg;

  // Number of frame bytes released with a closed frame (positions 1 to 6).
  localparam int unsigned FieldCount = 6;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_START_CHAR = 1'b0,
    REG_END_CHAR   = 1'b1
  } cfg_reg_e;

  typedef logic [7:0] byte_t;

  // Fields of one closed frame.
  typedef struct packed {
    byte_t command;
    byte_t group_class;
    byte_t content_0;
    byte_t content_1;
    byte_t content_2;
    byte_t content_3;
  } frame_res_t;

endpackage

// ----- hdl/dfr_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delimited frame parser
// Tracks the frame state for each accepted byte and flags a closed frame
// together with its six released bytes in the same cycle.
// ----------------------------------------------------------------------------
module dfr_parser #(
  parameter int unsigned BufBytes = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [7:0]         rx_byte_i,
  input  logic [7:0]         start_char_i,
  input  logic [7:0]         end_char_i,
  output logic               res_valid_o,
  output dfr_pkg::frame_res_t res_o
);
  import dfr_pkg::*;

  localparam int unsigned PosW = $clog2(BufBytes + 1);

  logic            in_frame_q, in_frame_d;
  logic [PosW-1:0] pos_q, pos_d;
  byte_t           bytes_q [FieldCount];
  byte_t           bytes_d [FieldCount];
  byte_t           bytes_w [FieldCount];

  logic [PosW-1:0] pos_inc;
  logic [PosW-1:0] pos_adv;
  logic            is_start, is_end, open_frame;

  assign is_start = (rx_byte_i == start_char_i);
  assign is_end   = (rx_byte_i == end_char_i);
  assign pos_inc  = pos_q + PosW'(1);
  // The position saturates at the store size.
  assign pos_adv  = (pos_q < PosW'(BufBytes)) ? pos_inc : pos_q;

  assign open_frame = accept_i && is_start;

  always_comb begin
    for (int k = 0; k < FieldCount; k++) begin
      bytes_w[k] = bytes_q[k];
      if (accept_i && in_frame_q && (pos_adv == PosW'(k + 1))) begin
        bytes_w[k] = rx_byte_i;
      end
      bytes_d[k] = open_frame ? '0 : bytes_w[k];
    end
  end

  always_comb begin
    in_frame_d  = in_frame_q;
    pos_d       = pos_q;
    res_valid_o = 1'b0;
    if (open_frame) begin
      in_frame_d = 1'b1;
      pos_d      = '0;
    end else if (accept_i && in_frame_q) begin
      pos_d = pos_adv;
      if (is_end) begin
        in_frame_d  = 1'b0;
        res_valid_o = 1'b1;
      end else if (pos_adv == PosW'(BufBytes)) begin
        // Overflow: the frame is dropped without a result.
        in_frame_d = 1'b0;
      end
    end
  end

  assign res_o.command     = bytes_w[0];
  assign res_o.group_class = bytes_w[1];
  assign res_o.content_0   = bytes_w[2];
  assign res_o.content_1   = bytes_w[3];
  assign res_o.content_2   = bytes_w[4];
  assign res_o.content_3   = bytes_w[5];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      pos_q      <= '0;
      for (int k = 0; k < FieldCount; k++) begin
        bytes_q[k] <= '0;
      end
    end else begin
      in_frame_q <= in_frame_d;
      pos_q      <= pos_d;
      for (int k = 0; k < FieldCount; k++) begin
        bytes_q[k] <= bytes_d[k];
      end
    end
  end

endmodule

// ----- hdl/delimited_frame_receiver.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delimited frame receiver
// Collects serial bytes between a start and an end character and releases
// the command, group and four content bytes of each closed frame.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries one received byte per item (in_valid_i,
// in_stall_o, rx_byte_i). The output channel carries one item per closed
// frame with six byte fields (out_valid_o, out_stall_i).
// A byte is taken every cycle while in_stall_o is low, so the sustained
// rate is one item per cycle. An accepted end byte's result is registered
// in the output register, or in the skid register while the output stalls.
// The user must write start and end characters through cfg_we_i, cfg_idx_i
// and cfg_data_i only while the block is idle, which it does not enforce.
// Reset clears the frame state, sets the start character to 0 and the end
// character to 255, and empties the output.
// When the receiver stalls, a second result is held in a skid register;
// in_stall_o rises only while that skid register is occupied, which frees
// the input again as soon as the receiver takes the waiting result.
// ----------------------------------------------------------------------------
module delimited_frame_receiver #(
  parameter int unsigned BUF_BYTES = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [0:0] cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] command_o,
  output logic [7:0] group_class_o,
  output logic [7:0] content_0_o,
  output logic [7:0] content_1_o,
  output logic [7:0] content_2_o,
  output logic [7:0] content_3_o
);
  import dfr_pkg::*;

  byte_t      start_char_q, end_char_q;
  logic       in_accept;
  logic       res_valid;
  frame_res_t res;

  logic       out_valid_q, skid_valid_q;
  frame_res_t out_q, skid_q;
  logic       out_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_char_q <= 8'd0;
      end_char_q   <= 8'd255;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_START_CHAR: start_char_q <= cfg_data_i;
        REG_END_CHAR:   end_char_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_stall_o = skid_valid_q;
  assign in_accept  = in_valid_i && !skid_valid_q;

  dfr_parser #(
    .BufBytes(BUF_BYTES)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_accept),
    .rx_byte_i   (rx_byte_i),
    .start_char_i(start_char_q),
    .end_char_i  (end_char_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign out_pop = out_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_pop || !out_valid_q) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= res_valid;
      end else begin
        out_valid_q <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_pop || !out_valid_q) begin
      if (skid_valid_q) begin
        out_q  <= skid_q;
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end else if (res_valid) begin
      skid_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign command_o     = out_q.command;
  assign group_class_o = out_q.group_class;
  assign content_0_o   = out_q.content_0;
  assign content_1_o   = out_q.content_1;
  assign content_2_o   = out_q.content_2;
  assign content_3_o   = out_q.content_3;

`ifndef ASSERT_OFF
  // The skid register only fills behind a held output register.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register valid while output register empty");

  // A result produced behind a stalled output lands in the skid register.
  a_result_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && out_valid_q && out_stall_i) |=> skid_valid_q)
    else $error("result lost behind stalled output");

  // A result comes only from an accepted byte.
  a_result_from_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> in_accept)
    else $error("result without an accepted item");

  // A waiting skid entry moves to the output when the output drains.
  a_skid_refill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_pop && skid_valid_q) |=> out_valid_q)
    else $error("skid entry not moved to output");
`endif

endmodule
